### design/cto_pkg.sv
// Package for the connection timeout queue: field widths, codes, cell
// command and view types, and the controller state type.
// No dependencies.
`default_nettype none

package cto_pkg;

    localparam int CAPACITY_DEF = 32;

    localparam int KIND_W    = 2;
    localparam int STATUS_W  = 3;
    localparam int CONN_W    = 16;
    localparam int SEQ_W     = 32;
    localparam int TIME_W    = 32;
    localparam int WAIT_W    = 16;
    localparam int CNT_W     = 6;
    localparam int S_TDATA_W = 80;
    localparam int M_TDATA_W = 64;
    localparam int M_PAD_W   = M_TDATA_W - (CONN_W + SEQ_W + 2 * CNT_W);

    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] REG_WAIT_TIME = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_KICK      = 1'd1;

    localparam logic [WAIT_W-1:0] WAIT_RESET = 16'd20;
    localparam logic              KICK_RESET = 1'b1;

    localparam logic [KIND_W-1:0] KIND_ADD    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DELETE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_TICK   = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_ADDED   = 3'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL    = 3'd1;
    localparam logic [STATUS_W-1:0] STATUS_DELETED = 3'd2;
    localparam logic [STATUS_W-1:0] STATUS_EXPIRED = 3'd3;
    localparam logic [STATUS_W-1:0] STATUS_NONE    = 3'd4;

    // operation broadcast to every cell of the chain
    typedef enum logic [2:0] {
        OP_HOLD,
        OP_INSERT,
        OP_SHIFT,
        OP_MARK_DEL,
        OP_MARK_DUE,
        OP_SWAP
    } cell_op_t;

    typedef struct packed {
        cell_op_t          op;
        logic              phase;
        logic [TIME_W-1:0] key;
        logic [CONN_W-1:0] conn;
        logic [SEQ_W-1:0]  seq;
    } cell_cmd_t;

    // what a cell shows its neighbors and the controller
    typedef struct packed {
        logic              valid;
        logic              due;
        logic              ins;
        logic              hit;
        logic [TIME_W-1:0] expiry;
        logic [CONN_W-1:0] conn;
        logic [SEQ_W-1:0]  seq;
    } cell_view_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_POP,
        ST_REARM,
        ST_COMPACT
    } state_t;

endpackage

`default_nettype wire

### design/cto_cell.sv
// One slot of the sorted deadline chain: holds one entry and trades it with
// its left and right neighbors on the broadcast command. Uses cto_pkg.
`default_nettype none

module cto_cell (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire cto_pkg::cell_cmd_t  cmd,
    input  wire logic                odd,
    input  wire cto_pkg::cell_view_t left,
    input  wire cto_pkg::cell_view_t right,
    output cto_pkg::cell_view_t      view
);

    logic                       valid_reg, valid_next;
    logic                       due_reg, due_next;
    logic [cto_pkg::TIME_W-1:0] exp_reg, exp_next;
    logic [cto_pkg::CONN_W-1:0] conn_reg, conn_next;
    logic [cto_pkg::SEQ_W-1:0]  seq_reg, seq_next;
    logic                       ins;
    logic                       lower;

    // insert point: first free slot or first live entry later than the key
    assign ins   = !valid_reg || (!due_reg && (exp_reg > cmd.key));
    assign lower = (odd == cmd.phase);

    assign view.valid  = valid_reg;
    assign view.due    = due_reg;
    assign view.ins    = ins;
    assign view.hit    = valid_reg && (conn_reg == cmd.conn);
    assign view.expiry = exp_reg;
    assign view.conn   = conn_reg;
    assign view.seq    = seq_reg;

    always_comb begin
        valid_next = valid_reg;
        due_next   = due_reg;
        exp_next   = exp_reg;
        conn_next  = conn_reg;
        seq_next   = seq_reg;
        case (cmd.op)
            cto_pkg::OP_INSERT: begin
                if (left.ins) begin
                    valid_next = left.valid;
                    due_next   = left.due;
                    exp_next   = left.expiry;
                    conn_next  = left.conn;
                    seq_next   = left.seq;
                end else if (ins) begin
                    valid_next = 1'b1;
                    due_next   = 1'b0;
                    exp_next   = cmd.key;
                    conn_next  = cmd.conn;
                    seq_next   = cmd.seq;
                end
            end
            cto_pkg::OP_SHIFT: begin
                valid_next = right.valid;
                due_next   = right.due;
                exp_next   = right.expiry;
                conn_next  = right.conn;
                seq_next   = right.seq;
            end
            cto_pkg::OP_MARK_DEL: begin
                if (view.hit) begin
                    valid_next = 1'b0;
                end
            end
            cto_pkg::OP_MARK_DUE: begin
                due_next = valid_reg && (exp_reg <= cmd.key);
            end
            cto_pkg::OP_SWAP: begin
                // odd-even transposition: holes drift right, live words keep order
                if (lower) begin
                    if (!valid_reg && right.valid) begin
                        valid_next = 1'b1;
                        due_next   = right.due;
                        exp_next   = right.expiry;
                        conn_next  = right.conn;
                        seq_next   = right.seq;
                    end
                end else begin
                    if (!left.valid && valid_reg) begin
                        valid_next = 1'b0;
                        due_next   = 1'b0;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            due_reg   <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            due_reg   <= due_next;
        end
        exp_reg  <= exp_next;
        conn_reg <= conn_next;
        seq_reg  <= seq_next;
    end

endmodule

`default_nettype wire

### design/connection_timeout_queue.sv
// Connection timeout queue: a chain of cto_cell slots kept sorted by expiry
// and then by age, with the controller that sequences add, delete and tick.
// Uses cto_pkg and cto_cell.
//
// Usage: s_ carries one command word (tuser = kind: add, delete, tick);
// m_ returns result words, the final one of each command with m_tlast.
// Config (wait time, kick mode) is written through cfg_wr_*; the user must
// do so only while idle, which the block does not enforce. Per command:
//   add, tick with nothing due, unknown kind: accept, then execute.
//   delete: accept, execute with the result, then odd-even compaction of
//     the chain before the next word is taken.
//   tick expiring k entries: accept, mark the due prefix, then one pop per
//     entry in kick mode, or a pop and a sorted insert each in re-arm mode.
// The chain does one operation per cycle, holding while a result waits for
// the output register; each cell only looks at its neighbors.
// A new word is taken while the previous result still sits in the output
// register; work that produces a result waits until that register frees.
// Reset empties the table and restores wait time 20 and kick mode on.
`default_nettype none

module connection_timeout_queue #(
    parameter int CAPACITY = cto_pkg::CAPACITY_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // [15:0] conn_id, [47:16] sequence_req, [79:48] now
    input  wire logic [cto_pkg::S_TDATA_W-1:0]     s_tdata,
    // [1:0] kind
    input  wire logic [cto_pkg::KIND_W-1:0]        s_tuser,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // [15:0] out_conn, [47:16] out_sequence, [53:48] removed_count,
    // [59:54] entry_count, [63:60] zero
    output logic [cto_pkg::M_TDATA_W-1:0]          m_tdata,
    // [2:0] status
    output logic [cto_pkg::STATUS_W-1:0]           m_tuser,
    output logic                                   m_tlast,
    input  wire logic                              cfg_wr_en,
    input  wire logic [cto_pkg::CFG_INDEX_W-1:0]   cfg_wr_index,
    input  wire logic [cto_pkg::CFG_DATA_W-1:0]    cfg_wr_data
);

    localparam int OCC_W = $clog2(CAPACITY + 1);

    localparam cto_pkg::cell_view_t EDGE_LEFT = '{
        valid: 1'b1, due: 1'b0, ins: 1'b0, hit: 1'b0,
        expiry: '0, conn: '0, seq: '0};
    localparam cto_pkg::cell_view_t EDGE_RIGHT = '{
        valid: 1'b0, due: 1'b0, ins: 1'b0, hit: 1'b0,
        expiry: '0, conn: '0, seq: '0};

    cto_pkg::state_t state_reg, state_next;

    logic [cto_pkg::KIND_W-1:0] kind_reg;
    logic [cto_pkg::CONN_W-1:0] conn_reg;
    logic [cto_pkg::SEQ_W-1:0]  seq_reg;
    logic [cto_pkg::TIME_W-1:0] now_reg;

    logic [cto_pkg::WAIT_W-1:0] wait_reg;
    logic                       kick_reg;

    logic [OCC_W-1:0] occ_reg, occ_next;
    logic [OCC_W-1:0] cnt_reg, cnt_next;
    logic             last_pop_reg, last_pop_next;
    logic [cto_pkg::CONN_W-1:0] hold_conn_reg, hold_conn_next;
    logic [cto_pkg::SEQ_W-1:0]  hold_seq_reg, hold_seq_next;

    logic                         m_tvalid_reg, m_tvalid_next;
    logic [cto_pkg::STATUS_W-1:0] out_status_reg, out_status_next;
    logic [cto_pkg::CONN_W-1:0]   out_conn_reg, out_conn_next;
    logic [cto_pkg::SEQ_W-1:0]    out_seq_reg, out_seq_next;
    logic [cto_pkg::CNT_W-1:0]    out_removed_reg, out_removed_next;
    logic [cto_pkg::CNT_W-1:0]    out_count_reg, out_count_next;
    logic                         out_last_reg, out_last_next;

    cto_pkg::cell_cmd_t  cmd;
    cto_pkg::cell_view_t cell_view [CAPACITY];
    cto_pkg::cell_view_t left_in   [CAPACITY];
    cto_pkg::cell_view_t right_in  [CAPACITY];
    logic [CAPACITY-1:0] hit_vec;
    logic [CAPACITY-1:0] valid_vec;

    logic                       in_accept;
    logic                       out_free;
    logic                       out_load;
    logic [cto_pkg::TIME_W-1:0] deadline;
    logic                       tick_work;
    logic                       pop_last;
    logic [OCC_W-1:0]           removed;

    function automatic logic [OCC_W-1:0] count_hits(input logic [CAPACITY-1:0] bits);
        logic [OCC_W-1:0] n;
        n = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            n = n + OCC_W'(bits[i]);
        end
        return n;
    endfunction

    // ---------------- cell chain ----------------
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        if (i == 0) begin : g_first
            assign left_in[i] = EDGE_LEFT;
        end else begin : g_mid_l
            assign left_in[i] = cell_view[i-1];
        end
        if (i == CAPACITY - 1) begin : g_last
            assign right_in[i] = EDGE_RIGHT;
        end else begin : g_mid_r
            assign right_in[i] = cell_view[i+1];
        end

        assign hit_vec[i]   = cell_view[i].hit;
        assign valid_vec[i] = cell_view[i].valid;

        cto_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .cmd     (cmd),
            .odd     (1'((i % 2) == 1)),
            .left    (left_in[i]),
            .right   (right_in[i]),
            .view    (cell_view[i])
        );
    end

    // ---------------- handshake and shared terms ----------------
    assign s_tready  = (state_reg == cto_pkg::ST_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign deadline  = now_reg + {{(cto_pkg::TIME_W - cto_pkg::WAIT_W){1'b0}}, wait_reg};
    assign tick_work = (occ_reg != '0) && (cell_view[0].expiry < now_reg);
    assign pop_last  = !cell_view[1].due;
    assign removed   = count_hits(hit_vec);

    // ---------------- next state ----------------
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            cto_pkg::ST_IDLE: begin
                if (in_accept) begin
                    state_next = cto_pkg::ST_EXEC;
                end
            end
            cto_pkg::ST_EXEC: begin
                if (out_free) begin
                    if (kind_reg == cto_pkg::KIND_DELETE) begin
                        state_next = cto_pkg::ST_COMPACT;
                    end else if (kind_reg == cto_pkg::KIND_TICK && tick_work) begin
                        state_next = cto_pkg::ST_POP;
                    end else begin
                        state_next = cto_pkg::ST_IDLE;
                    end
                end
            end
            cto_pkg::ST_POP: begin
                if (out_free) begin
                    if (!kick_reg) begin
                        state_next = cto_pkg::ST_REARM;
                    end else if (pop_last) begin
                        state_next = cto_pkg::ST_IDLE;
                    end
                end
            end
            cto_pkg::ST_REARM: begin
                state_next = last_pop_reg ? cto_pkg::ST_IDLE : cto_pkg::ST_POP;
            end
            cto_pkg::ST_COMPACT: begin
                if (cnt_reg == OCC_W'(1)) begin
                    state_next = cto_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = cto_pkg::ST_IDLE;
            end
        endcase
    end

    // ---------------- datapath control ----------------
    always_comb begin
        cmd.op    = cto_pkg::OP_HOLD;
        cmd.phase = cnt_reg[0];
        cmd.key   = now_reg;
        cmd.conn  = conn_reg;
        cmd.seq   = seq_reg;

        occ_next       = occ_reg;
        cnt_next       = cnt_reg;
        last_pop_next  = last_pop_reg;
        hold_conn_next = hold_conn_reg;
        hold_seq_next  = hold_seq_reg;

        out_load         = 1'b0;
        out_status_next  = out_status_reg;
        out_conn_next    = out_conn_reg;
        out_seq_next     = out_seq_reg;
        out_removed_next = out_removed_reg;
        out_count_next   = out_count_reg;
        out_last_next    = out_last_reg;

        case (state_reg)
            cto_pkg::ST_EXEC: begin
                if (out_free) begin
                    out_load         = 1'b1;
                    out_status_next  = cto_pkg::STATUS_NONE;
                    out_conn_next    = conn_reg;
                    out_seq_next     = '0;
                    out_removed_next = '0;
                    out_count_next   = cto_pkg::CNT_W'(occ_reg);
                    out_last_next    = 1'b1;
                    case (kind_reg)
                        cto_pkg::KIND_ADD: begin
                            if (occ_reg == OCC_W'(CAPACITY)) begin
                                out_status_next = cto_pkg::STATUS_FULL;
                            end else begin
                                cmd.op          = cto_pkg::OP_INSERT;
                                cmd.key         = deadline;
                                occ_next        = occ_reg + OCC_W'(1);
                                out_status_next = cto_pkg::STATUS_ADDED;
                                out_count_next  = cto_pkg::CNT_W'(occ_reg + OCC_W'(1));
                            end
                        end
                        cto_pkg::KIND_DELETE: begin
                            cmd.op           = cto_pkg::OP_MARK_DEL;
                            occ_next         = occ_reg - removed;
                            cnt_next         = OCC_W'(CAPACITY);
                            out_status_next  = cto_pkg::STATUS_DELETED;
                            out_removed_next = cto_pkg::CNT_W'(removed);
                            out_count_next   = cto_pkg::CNT_W'(occ_reg - removed);
                        end
                        cto_pkg::KIND_TICK: begin
                            if (tick_work) begin
                                // mark the due prefix; results come from the pops
                                cmd.op   = cto_pkg::OP_MARK_DUE;
                                out_load = 1'b0;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            cto_pkg::ST_POP: begin
                if (out_free) begin
                    cmd.op           = cto_pkg::OP_SHIFT;
                    out_load         = 1'b1;
                    out_status_next  = cto_pkg::STATUS_EXPIRED;
                    out_conn_next    = cell_view[0].conn;
                    out_seq_next     = cell_view[0].seq;
                    out_removed_next = '0;
                    out_last_next    = pop_last;
                    last_pop_next    = pop_last;
                    hold_conn_next   = cell_view[0].conn;
                    hold_seq_next    = cell_view[0].seq;
                    if (kick_reg) begin
                        occ_next       = occ_reg - OCC_W'(1);
                        out_count_next = cto_pkg::CNT_W'(occ_reg - OCC_W'(1));
                    end else begin
                        out_count_next = cto_pkg::CNT_W'(occ_reg);
                    end
                end
            end
            cto_pkg::ST_REARM: begin
                cmd.op   = cto_pkg::OP_INSERT;
                cmd.key  = deadline;
                cmd.conn = hold_conn_reg;
                cmd.seq  = hold_seq_reg;
            end
            cto_pkg::ST_COMPACT: begin
                cmd.op   = cto_pkg::OP_SWAP;
                cnt_next = cnt_reg - OCC_W'(1);
            end
            default: begin
            end
        endcase

        if (out_load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end else begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    // ---------------- registers ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= cto_pkg::ST_IDLE;
            occ_reg      <= '0;
            cnt_reg      <= '0;
            last_pop_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
            wait_reg     <= cto_pkg::WAIT_RESET;
            kick_reg     <= cto_pkg::KICK_RESET;
        end else begin
            state_reg    <= state_next;
            occ_reg      <= occ_next;
            cnt_reg      <= cnt_next;
            last_pop_reg <= last_pop_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_wr_en) begin
                case (cfg_wr_index)
                    cto_pkg::REG_WAIT_TIME: wait_reg <= cfg_wr_data[cto_pkg::WAIT_W-1:0];
                    cto_pkg::REG_KICK:      kick_reg <= cfg_wr_data[0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            kind_reg <= s_tuser;
            conn_reg <= s_tdata[15:0];
            seq_reg  <= s_tdata[47:16];
            now_reg  <= s_tdata[79:48];
        end
        hold_conn_reg   <= hold_conn_next;
        hold_seq_reg    <= hold_seq_next;
        out_status_reg  <= out_status_next;
        out_conn_reg    <= out_conn_next;
        out_seq_reg     <= out_seq_next;
        out_removed_reg <= out_removed_next;
        out_count_reg   <= out_count_next;
        out_last_reg    <= out_last_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {{cto_pkg::M_PAD_W{1'b0}}, out_count_reg, out_removed_reg,
                       out_seq_reg, out_conn_reg};

    // ---------------- assertions ----------------
    a_occ_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        occ_reg <= OCC_W'(CAPACITY))
        else $error("occupancy above capacity");

    a_idle_packed: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == cto_pkg::ST_IDLE) |-> ($countones(valid_vec) == occ_reg))
        else $error("live slot count differs from occupancy");

    a_pop_head_due: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == cto_pkg::ST_POP) |-> (cell_view[0].valid && cell_view[0].due))
        else $error("pop without a due entry at the head");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> out_free)
        else $error("result register overwritten");

endmodule

`default_nettype wire
